FILE: design/single_wire_frame_transmitter_top_assert.svh
// Assertion macros shared by the single-wire frame transmitter RTL.
`ifndef SINGLE_WIRE_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define SINGLE_WIRE_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SWFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define SWFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/swft_pkg.sv
// Package for the single-wire frame transmitter: codes, widths and reset values.
package swft_pkg;

	// Command codes carried in func
	localparam int FUNC_W = 2;
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SEND = 2'd1,
		FUNC_WAIT = 2'd2,
		FUNC_HOLD = 2'd3
	} func_t;

	// Configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PHASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_HIGH  = 2'd2;

	// Register widths and reset values
	localparam int SHORT_W = 8;
	localparam int STOP_W  = 8;
	localparam int LATCH_W = 10;
	localparam logic [SHORT_W-1:0] SHORT_PHASE_RST = 8'd3;
	localparam logic [STOP_W-1:0]  STOP_LOW_RST    = 8'd12;
	localparam logic [LATCH_W-1:0] LATCH_HIGH_RST  = 10'd300;

	// Phase countdown holds up to three short phases or the latch time
	localparam int CNT_W = 10;

	// Default frame layout
	localparam int ADDR_BITS_DEF = 3;
	localparam int DATA_BITS_DEF = 8;

endpackage

FILE: design/single_wire_frame_transmitter_top.sv
// Single-wire frame transmitter: pulse-width coded frames on an idle-high wire.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries func, reg_addr, reg_value. func selects
//    a one-microsecond tick, a frame send, an idle-high wait or a hold-low command.
//  - Output channel (out_valid/out_ready) returns one transaction per input: the wire
//    level after the item, busy_res, and refused for a send, wait or hold while busy.
//  - Configuration: cfg_wr_en/cfg_index/cfg_data write short phase, stop low and latch
//    high lengths; write only while the block is idle. Unknown indexes are ignored.
// Timing:
//  - An accepted item lands in the input register, is processed in one pass against the
//    frame state and its result moves to the output register, which drives out_valid,
//    as soon as the output register is free.
//  - One item per cycle while out_ready is high; the single in/out register pair sets it.
//  - When out_ready is low the output register holds; the input register still takes
//    one more item, then in_ready drops until the output drains.
// Reset:
//  - arst_n clears the pipeline, returns the line high and idle, and restores the
//    register defaults (3, 12, 300).
`include "single_wire_frame_transmitter_top_assert.svh"

module single_wire_frame_transmitter_top #(
	parameter int ADDR_BITS = swft_pkg::ADDR_BITS_DEF,
	parameter int DATA_BITS = swft_pkg::DATA_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_wr_en,
	input  logic [swft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swft_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [swft_pkg::FUNC_W-1:0]      func,
	input  logic [ADDR_BITS-1:0]             reg_addr,
	input  logic [DATA_BITS-1:0]             reg_value,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             line_level,
	output logic                             busy_res,
	output logic                             refused
);
	import swft_pkg::*;

	localparam int FB_W        = ADDR_BITS + DATA_BITS;
	localparam int PH_W        = $clog2(2 * FB_W + 2);
	localparam int STOP_PH_I   = 2 * FB_W;
	localparam int LATCH_PH_I  = 2 * FB_W + 1;
	localparam logic [PH_W-1:0] STOP_PH  = PH_W'(STOP_PH_I);
	localparam logic [PH_W-1:0] LATCH_PH = PH_W'(LATCH_PH_I);

	// configuration registers
	logic [SHORT_W-1:0] short_phase_q;
	logic [STOP_W-1:0]  stop_low_q;
	logic [LATCH_W-1:0] latch_high_q;

	// frame state
	logic            wire_q, wire_d;
	logic [PH_W-1:0] phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [FB_W-1:0] bits_q, bits_d;
	logic            active_q, active_d;
	logic            wait_q, wait_d;
	logic            refused_d;

	// pipeline registers
	logic                 valid_s1;
	func_t                func_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [DATA_BITS-1:0] value_s1;
	logic                 valid_s2;
	logic                 level_s2, busy_s2, refused_s2;

	logic adv_s1, take_in;

	// load helpers
	logic             do_load;
	logic [CNT_W-1:0] short_len, long_len;
	logic [FB_W-1:0]  bits_sh;
	logic             cur_bit;

	// handshake: output stage frees when empty or drained
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign take_in   = in_valid && in_ready;
	assign out_valid = valid_s2;
	assign line_level = level_s2;
	assign busy_res   = busy_s2;
	assign refused    = refused_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_phase_q <= SHORT_PHASE_RST;
			stop_low_q    <= STOP_LOW_RST;
			latch_high_q  <= LATCH_HIGH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SHORT_PHASE: short_phase_q <= cfg_data[SHORT_W-1:0];
				REG_STOP_LOW:    stop_low_q    <= cfg_data[STOP_W-1:0];
				REG_LATCH_HIGH:  latch_high_q  <= cfg_data[LATCH_W-1:0];
				default: ;
			endcase
		end
	end

	// phase lengths
	assign short_len = CNT_W'(short_phase_q);
	assign long_len  = CNT_W'({short_phase_q, 1'b0}) + CNT_W'(short_phase_q);

	// next frame state for the transaction in stage 1
	always_comb begin
		wire_d    = wire_q;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		bits_d    = bits_q;
		active_d  = active_q;
		wait_d    = wait_q;
		refused_d = 1'b0;
		do_load   = 1'b0;
		bits_sh   = '0;
		cur_bit   = 1'b0;
		case (func_s1)
			FUNC_TICK: begin
				if (active_q) begin
					if (cnt_q > CNT_W'(1)) begin
						cnt_d = cnt_q - CNT_W'(1);
					end else if (wait_q || phase_q >= LATCH_PH) begin
						active_d = 1'b0;
						wait_d   = 1'b0;
						wire_d   = 1'b1;
						phase_d  = '0;
						cnt_d    = '0;
					end else begin
						phase_d = phase_q + PH_W'(1);
						do_load = 1'b1;
					end
				end
			end
			FUNC_SEND: begin
				if (active_q) begin
					refused_d = 1'b1;
				end else begin
					bits_d   = {value_s1, addr_s1};
					active_d = 1'b1;
					wait_d   = 1'b0;
					phase_d  = '0;
					do_load  = 1'b1;
				end
			end
			FUNC_WAIT: begin
				if (active_q) begin
					refused_d = 1'b1;
				end else begin
					active_d = 1'b1;
					wait_d   = 1'b1;
					phase_d  = '0;
					wire_d   = 1'b1;
					cnt_d    = CNT_W'(stop_low_q);
				end
			end
			FUNC_HOLD: begin
				if (active_q) begin
					refused_d = 1'b1;
				end else begin
					wire_d = 1'b0;
				end
			end
			default: ;
		endcase

		// phase load: bit phases, then stop low, then latch high
		if (do_load) begin
			bits_sh = bits_d >> phase_d[PH_W-1:1];
			cur_bit = bits_sh[0];
			if (phase_d < STOP_PH) begin
				if (!phase_d[0]) begin
					wire_d = 1'b0;
					cnt_d  = cur_bit ? long_len : short_len;
				end else begin
					wire_d = 1'b1;
					cnt_d  = cur_bit ? short_len : long_len;
				end
			end else if (phase_d == STOP_PH) begin
				wire_d = 1'b0;
				cnt_d  = CNT_W'(stop_low_q);
			end else begin
				wire_d = 1'b1;
				cnt_d  = CNT_W'(latch_high_q);
			end
		end
	end

	// control: stage valids and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			wire_q   <= 1'b1;
			phase_q  <= '0;
			cnt_q    <= '0;
			bits_q   <= '0;
			active_q <= 1'b0;
			wait_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s1) begin
				wire_q   <= wire_d;
				phase_q  <= phase_d;
				cnt_q    <= cnt_d;
				bits_q   <= bits_d;
				active_q <= active_d;
				wait_q   <= wait_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1  <= func_t'(func);
			addr_s1  <= reg_addr;
			value_s1 <= reg_value;
		end
		if (adv_s1) begin
			level_s2   <= wire_d;
			busy_s2    <= active_d;
			refused_s2 <= refused_d;
		end
	end

	// checks on the frame state and results
	`SWFT_ASSERT_NOW(a_idle_phase_zero, !active_q, phase_q == '0 && cnt_q == '0 && !wait_q,
		"idle block holds phase or countdown")
	`SWFT_ASSERT_NOW(a_phase_range, active_q, phase_q <= LATCH_PH,
		"phase number past latch phase")
	`SWFT_ASSERT_NOW(a_refused_busy, valid_s2 && refused_s2, busy_s2,
		"refused transaction reported while free")
	`SWFT_ASSERT_NEXT(a_state_hold, !adv_s1, $stable(active_q) && $stable(cnt_q),
		"frame state moved without a transaction")

endmodule
